// ===== src/svpc_pkg.sv =====
`default_nettype none

package svpc_pkg;

   localparam int SERVO_COUNT = 3;
   localparam int PULSE_W     = 12;
   localparam int AGE_W       = 16;
   localparam int VALUE_W     = 16;
   localparam int LIMIT_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // Widths along the angle scaling path.
   localparam int PROD_W      = 33;
   localparam int MAG_W       = 29;
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 35;
   localparam int RP_W        = MAG_W + RECIP_W;
   localparam int QUO_W       = RP_W - RECIP_SHIFT;
   localparam int QUOT_W      = QUO_W + 1;
   localparam int REM_W       = MAG_W + 1;
   localparam int PSUM_W      = QUOT_W + 1;

   // The angle span of 180 degrees is split into a shift by two and a divide by 45.
   localparam int DIV_REST = 45;
   localparam logic [RECIP_W-1:0] RECIP_45 =
      RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_REST);

   localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};
   localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};

   localparam logic [1:0] REQ_ANGLE = 2'd0;
   localparam logic [1:0] REQ_PULSE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [1:0] MODE_ACTIVE = 2'd0;
   localparam logic [1:0] MODE_MENU   = 2'd1;
   localparam logic [1:0] MODE_CAL    = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_A  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_B  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_C  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE    = 3'd7;

   localparam logic [CSR_DATA_W-1:0] LIMITS_RESET  = 32'd131073000;
   localparam logic [PULSE_W-1:0]    CENTRE_RESET  = 12'd1500;
   localparam logic [AGE_W-1:0]      TIMEOUT_RESET = 16'd500;
   localparam logic [AGE_W-1:0]      SETTLE_RESET  = 16'd1000;

   typedef struct packed {
      logic [1:0]                req;
      logic [1:0]                idx;
      logic signed [VALUE_W-1:0] value;
      logic [1:0]                mode;
   } item_type;

   typedef struct packed {
      logic [SERVO_COUNT-1:0][CSR_DATA_W-1:0] limits;
      logic [SERVO_COUNT-1:0][PULSE_W-1:0]    centre;
      logic [AGE_W-1:0]                       timeout;
      logic [AGE_W-1:0]                       settle;
   } cfg_type;

   // Servo index three selects nothing useful; callers ignore the result then.
   function automatic logic [CSR_DATA_W-1:0] pick_limits(cfg_type cfg, logic [1:0] idx);
      logic [CSR_DATA_W-1:0] lim;
      unique case (idx)
         2'd1:    lim = cfg.limits[1];
         2'd2:    lim = cfg.limits[2];
         default: lim = cfg.limits[0];
      endcase
      return lim;
   endfunction

   function automatic logic [AGE_W-1:0] age_up(logic [AGE_W-1:0] age);
      return (age == AGE_MAX) ? AGE_MAX : age + AGE_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== src/svpc_csr.sv =====
`default_nettype none

module svpc_csr import svpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SERVO_COUNT; s++) begin
            cfg_ff.limits[s] <= LIMITS_RESET;
            cfg_ff.centre[s] <= CENTRE_RESET;
         end
         cfg_ff.timeout <= TIMEOUT_RESET;
         cfg_ff.settle  <= SETTLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LIMITS_A: cfg_ff.limits[0] <= csr_wdata;
            CSR_LIMITS_B: cfg_ff.limits[1] <= csr_wdata;
            CSR_LIMITS_C: cfg_ff.limits[2] <= csr_wdata;
            CSR_CENTRE_A: cfg_ff.centre[0] <= csr_wdata[PULSE_W-1:0];
            CSR_CENTRE_B: cfg_ff.centre[1] <= csr_wdata[PULSE_W-1:0];
            CSR_CENTRE_C: cfg_ff.centre[2] <= csr_wdata[PULSE_W-1:0];
            CSR_TIMEOUT:  cfg_ff.timeout   <= csr_wdata[AGE_W-1:0];
            CSR_SETTLE:   cfg_ff.settle    <= csr_wdata[AGE_W-1:0];
            default:      cfg_ff.settle    <= cfg_ff.settle;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/svpc_scale.sv =====
`default_nettype none

module svpc_scale import svpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  item_type                 in_item,
   input  cfg_type                  cfg,
   output logic                     out_valid,
   output item_type                 out_item,
   output logic signed [QUOT_W-1:0] out_quot
);

   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   item_type s0_item_ff, s1_item_ff, s2_item_ff, s3_item_ff;

   logic [CSR_DATA_W-1:0]     s0_lim;
   logic signed [PROD_W-1:0]  s0_val_ext;
   logic signed [PROD_W-1:0]  s0_diff_ext;
   logic signed [PROD_W-1:0]  s1_prod_in, s1_prod_ff;

   logic [PROD_W-1:0]         s1_mag;
   logic [MAG_W-1:0]          s2_mag_in, s2_mag_ff;
   logic [RP_W-1:0]           s2_rp_in, s2_rp_ff;
   logic                      s2_neg_ff;

   logic [QUO_W-1:0]          s2_q0, s2_q;
   logic [REM_W-1:0]          s2_q0x45, s2_rem;
   logic signed [QUOT_W-1:0]  s3_quot_in, s3_quot_ff;

   // Stage 1: degrees times the servo's span (max - min).
   always_comb begin
      s0_lim      = pick_limits(cfg, s0_item_ff.idx);
      s0_val_ext  = PROD_W'(s0_item_ff.value);
      s0_diff_ext = $signed({(PROD_W-LIMIT_W)'(0), s0_lim[2*LIMIT_W-1:LIMIT_W]})
                  - $signed({(PROD_W-LIMIT_W)'(0), s0_lim[LIMIT_W-1:0]});
      s1_prod_in  = s0_val_ext * s0_diff_ext;
   end

   // Stage 2: the magnitude divided by four, times the reciprocal of 45.
   always_comb begin
      s1_mag    = s1_prod_ff[PROD_W-1] ? PROD_W'(-s1_prod_ff) : PROD_W'(s1_prod_ff);
      s2_mag_in = s1_mag[MAG_W+1:2];
      s2_rp_in  = RP_W'(s2_mag_in) * RP_W'(RECIP_45);
   end

   // Stage 3: the estimate is at most one low, so one remainder check fixes it.
   always_comb begin
      s2_q0    = s2_rp_ff[RP_W-1:RECIP_SHIFT];
      s2_q0x45 = (REM_W'(s2_q0) << 5) + (REM_W'(s2_q0) << 3)
               + (REM_W'(s2_q0) << 2) + REM_W'(s2_q0);
      s2_rem   = REM_W'(s2_mag_ff) - s2_q0x45;
      s2_q     = (s2_rem >= REM_W'(DIV_REST)) ? s2_q0 + QUO_W'(1) : s2_q0;
      s3_quot_in = s2_neg_ff ? -$signed({1'b0, s2_q}) : $signed({1'b0, s2_q});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_item_ff <= in_item;
         s1_item_ff <= s0_item_ff;
         s1_prod_ff <= s1_prod_in;
         s2_item_ff <= s1_item_ff;
         s2_mag_ff  <= s2_mag_in;
         s2_rp_ff   <= s2_rp_in;
         s2_neg_ff  <= s1_prod_ff[PROD_W-1];
         s3_item_ff <= s2_item_ff;
         s3_quot_ff <= s3_quot_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;
   assign out_quot  = s3_quot_ff;

endmodule

`default_nettype wire

// ===== src/svpc_state.sv =====
`default_nettype none

module svpc_state import svpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  item_type                 in_item,
   input  logic signed [QUOT_W-1:0] in_quot,
   input  cfg_type                  cfg,
   output logic                     rsp_valid,
   output logic [PULSE_W-1:0]       rsp_pulse_a,
   output logic [PULSE_W-1:0]       rsp_pulse_b,
   output logic [PULSE_W-1:0]       rsp_pulse_c,
   output logic                     rsp_drive_enabled,
   output logic                     rsp_timed_out,
   output logic [PULSE_W-1:0]       rsp_applied_pulse
);

   logic [SERVO_COUNT-1:0][PULSE_W-1:0] pulse_ff, pulse_in;
   logic             drive_on_ff, drive_on_in;
   logic [1:0]       prev_mode_ff, prev_mode_in;
   logic [AGE_W-1:0] cmd_age_ff, cmd_age_in;
   logic [AGE_W-1:0] idle_age_ff, idle_age_in;

   logic             rsp_valid_ff;
   logic             timed_out_ff, timed_out_in;
   logic [PULSE_W-1:0] applied_ff, applied_in;

   logic                      fire;
   logic                      is_set, is_tick, entered;
   logic [CSR_DATA_W-1:0]     lim;
   logic [LIMIT_W-1:0]        lo, hi, clamped;
   logic signed [PSUM_W-1:0]  raw, lo_ext, hi_ext;

   assign fire    = advance && in_valid;
   assign is_set  = ((in_item.req == REQ_ANGLE) || (in_item.req == REQ_PULSE))
                 && (in_item.idx != 2'd3);
   assign is_tick = (in_item.req == REQ_TICK);

   // Clamp to the servo's limits, min first, then saturate to the store width.
   always_comb begin
      lim    = pick_limits(cfg, in_item.idx);
      lo     = lim[LIMIT_W-1:0];
      hi     = lim[2*LIMIT_W-1:LIMIT_W];
      lo_ext = $signed({(PSUM_W-LIMIT_W)'(0), lo});
      hi_ext = $signed({(PSUM_W-LIMIT_W)'(0), hi});
      if (in_item.req == REQ_ANGLE) begin
         raw = PSUM_W'(in_quot) + lo_ext;
      end else begin
         raw = PSUM_W'(in_item.value);
      end
      priority if (raw < lo_ext) begin
         clamped = lo;
      end else if (raw > hi_ext) begin
         clamped = hi;
      end else begin
         clamped = raw[LIMIT_W-1:0];
      end
      applied_in = (clamped > LIMIT_W'(PULSE_MAX)) ? PULSE_MAX : clamped[PULSE_W-1:0];
   end

   always_comb begin
      pulse_in     = pulse_ff;
      drive_on_in  = drive_on_ff;
      prev_mode_in = prev_mode_ff;
      cmd_age_in   = cmd_age_ff;
      idle_age_in  = idle_age_ff;
      timed_out_in = 1'b0;
      entered      = (in_item.mode != prev_mode_ff);
      if (is_set) begin
         pulse_in[in_item.idx] = applied_in;
         cmd_age_in = '0;
      end else if (is_tick) begin
         prev_mode_in = in_item.mode;
         cmd_age_in   = age_up(cmd_age_ff);
         idle_age_in  = age_up(idle_age_ff);
         priority if (in_item.mode == MODE_CAL) begin
            drive_on_in = 1'b0;
         end else if (in_item.mode == MODE_MENU) begin
            if (entered) begin
               pulse_in    = cfg.centre;
               drive_on_in = 1'b1;
               idle_age_in = '0;
            end else if (drive_on_ff && (idle_age_in >= cfg.settle)) begin
               drive_on_in = 1'b0;
            end
         end else begin
            // Active mode; an undefined mode code behaves the same.
            if (!drive_on_ff) begin
               pulse_in    = cfg.centre;
               drive_on_in = 1'b1;
            end
            if (cmd_age_in >= cfg.timeout) begin
               pulse_in     = cfg.centre;
               timed_out_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff     <= '0;
         drive_on_ff  <= 1'b0;
         prev_mode_ff <= MODE_NONE;
         cmd_age_ff   <= '0;
         idle_age_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid;
         if (in_valid) begin
            pulse_ff     <= pulse_in;
            drive_on_ff  <= drive_on_in;
            prev_mode_ff <= prev_mode_in;
            cmd_age_ff   <= cmd_age_in;
            idle_age_ff  <= idle_age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         timed_out_ff <= timed_out_in;
         applied_ff   <= is_set ? applied_in : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_a       = pulse_ff[0];
   assign rsp_pulse_b       = pulse_ff[1];
   assign rsp_pulse_c       = pulse_ff[2];
   assign rsp_drive_enabled = drive_on_ff;
   assign rsp_timed_out     = timed_out_ff;
   assign rsp_applied_pulse = applied_ff;

   a_timeout_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && timed_out_ff |-> drive_on_ff)
      else $error("timeout reported while drive is off");

   a_timeout_centres: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && timed_out_ff |-> (pulse_ff == cfg.centre))
      else $error("timeout did not recentre the servos");

   a_set_clears_age: assert property (@(posedge clock) disable iff (reset)
      fire && is_set |=> (cmd_age_ff == '0))
      else $error("set word did not clear the command age");

   a_cal_stops_drive: assert property (@(posedge clock) disable iff (reset)
      fire && is_tick && (in_item.mode == MODE_CAL) |=> !drive_on_ff)
      else $error("calibration tick left the drive on");

endmodule

`default_nettype wire

// ===== src/servo_pulse_controller_with_timeout.sv =====
// Throughput: one word per cycle while the result register is empty or being taken;
// a word passes the input register, three scaling stages for the angle multiply and
// divide by 180, and the state update, each of them a register.
// Reset is synchronous and active high: pulses read zero, the drive is off, ages are
// zero, the previous mode is none and the configuration registers take their defaults.
`default_nettype none

module servo_pulse_controller_with_timeout import svpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [1:0]                req_servo_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [1:0]                req_mode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PULSE_W-1:0]        rsp_pulse_a,
   output logic [PULSE_W-1:0]        rsp_pulse_b,
   output logic [PULSE_W-1:0]        rsp_pulse_c,
   output logic                      rsp_drive_enabled,
   output logic                      rsp_timed_out,
   output logic [PULSE_W-1:0]        rsp_applied_pulse,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type  cfg;
   item_type in_item, sc_item;
   logic     sc_valid;
   logic     advance;
   logic signed [QUOT_W-1:0] sc_quot;

   // The whole pipeline moves whenever the result register is empty or being taken.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign in_item.req   = req_type;
   assign in_item.idx   = req_servo_index;
   assign in_item.value = req_value;
   assign in_item.mode  = req_mode;

   svpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   svpc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (in_item),
      .cfg       (cfg),
      .out_valid (sc_valid),
      .out_item  (sc_item),
      .out_quot  (sc_quot)
   );

   svpc_state u_state (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (sc_valid),
      .in_item           (sc_item),
      .in_quot           (sc_quot),
      .cfg               (cfg),
      .rsp_valid         (rsp_valid),
      .rsp_pulse_a       (rsp_pulse_a),
      .rsp_pulse_b       (rsp_pulse_b),
      .rsp_pulse_c       (rsp_pulse_c),
      .rsp_drive_enabled (rsp_drive_enabled),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_applied_pulse (rsp_applied_pulse)
   );

endmodule

`default_nettype wire
